[design/tip_pkg.sv]
// shared types, constants and a helper function of the text to integer parser
package tip_pkg;

   localparam int VALUE_WIDTH  = 64;
   localparam int MAX_CONSUMED = 65535;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   localparam logic [5:0] BASE_AUTO    = 6'd0;
   localparam logic [5:0] BASE_ONE     = 6'd1;
   localparam logic [5:0] BASE_EIGHT   = 6'd8;
   localparam logic [5:0] BASE_TEN     = 6'd10;
   localparam logic [5:0] BASE_SIXTEEN = 6'd16;
   localparam logic [5:0] BASE_MAX     = 6'd36;
   localparam logic [5:0] NO_DIGIT     = 6'd63;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'b00001,
      PH_SPACE  = 5'b00010,
      PH_SIGNED = 5'b00100,
      PH_ZERO   = 5'b01000,
      PH_DIGITS = 5'b10000
   } phase_type;

   // one classified text byte as it travels from front to back
   typedef struct packed {
      logic       start;
      logic [5:0] base;
      logic       is_space;
      logic       is_sign;
      logic       is_minus;
      logic       is_zero;
      logic       is_x;
      logic       is_nul;
      logic [5:0] digit;
   } entry_type;

   function automatic logic [15:0] count_inc(input logic [15:0] count);
      logic [15:0] result;
      result = count;
      if (count < 16'(MAX_CONSUMED)) begin
         result = count + 16'd1;
      end
      return result;
   endfunction

endpackage

[design/tip_front.sv]
// front unit: base register, byte classification and base resolution
module tip_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [5:0]          csr_requested_base,
   input  logic [7:0]          req_character,
   input  logic                req_start_of_text,
   output tip_pkg::entry_type  entry
);

   logic [5:0] base_ff;
   logic [5:0] base_in;
   logic [7:0] c;

   assign csr_ready = 1'b1;
   assign c = req_character;

   always_comb begin
      base_in = base_ff;
      if (csr_valid && csr_ready) begin
         base_in = csr_requested_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= tip_pkg::BASE_AUTO;
      end else begin
         base_ff <= base_in;
      end
   end

   always_comb begin
      entry.start = req_start_of_text;
      if (base_ff == tip_pkg::BASE_ONE || base_ff > tip_pkg::BASE_MAX) begin
         entry.base = tip_pkg::BASE_TEN;
      end else begin
         entry.base = base_ff;
      end
      entry.is_space = (c == tip_pkg::CHAR_SPACE) || (c == tip_pkg::CHAR_TAB);
      entry.is_sign  = (c == tip_pkg::CHAR_PLUS) || (c == tip_pkg::CHAR_MINUS);
      entry.is_minus = (c == tip_pkg::CHAR_MINUS);
      entry.is_zero  = (c == tip_pkg::CHAR_ZERO);
      entry.is_x     = (c == tip_pkg::CHAR_UPPER_X) || (c == tip_pkg::CHAR_LOWER_X);
      entry.is_nul   = (c == tip_pkg::CHAR_NUL);
      priority if (c >= tip_pkg::CHAR_ZERO && c <= tip_pkg::CHAR_NINE) begin
         entry.digit = 6'(c - tip_pkg::CHAR_ZERO);
      end else if (c >= tip_pkg::CHAR_UPPER_A && c <= tip_pkg::CHAR_UPPER_Z) begin
         entry.digit = 6'(c - tip_pkg::CHAR_UPPER_A + 8'd10);
      end else if (c >= tip_pkg::CHAR_LOWER_A && c <= tip_pkg::CHAR_LOWER_Z) begin
         entry.digit = 6'(c - tip_pkg::CHAR_LOWER_A + 8'd10);
      end else begin
         entry.digit = tip_pkg::NO_DIGIT;
      end
   end

endmodule

[design/tip_fifo.sv]
// short queue of classified items between front and back
module tip_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  tip_pkg::entry_type  push_entry,
   input  logic                pop,
   output logic                empty,
   output tip_pkg::entry_type  head_entry
);

   tip_pkg::entry_type                 slot_ff [tip_pkg::QUEUE_DEPTH];
   logic [tip_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tip_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tip_pkg::QUEUE_PTR_W:0]      count_ff, count_in;
   logic                               do_push, do_pop;

   assign full       = (count_ff == (tip_pkg::QUEUE_PTR_W+1)'(tip_pkg::QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[design/tip_back.sv]
// back unit: parse phases, multiply-add accumulator and result register
module tip_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                entry_empty,
   input  tip_pkg::entry_type  entry,
   output logic                entry_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic signed [63:0]  rsp_parsed_value,
   output logic [15:0]         rsp_consumed_count,
   output logic                rsp_stopped_at_terminator
);

   localparam int W = tip_pkg::VALUE_WIDTH;

   tip_pkg::phase_type phase_ff, phase_in;
   logic               neg_ff, neg_in;
   logic [5:0]         base_ff, base_in;
   logic [W-1:0]       acc_ff, acc_in;
   logic [15:0]        cnt_ff, cnt_in;

   logic               out_valid_ff, out_valid_in;
   logic signed [63:0] out_value_ff, out_value_in;
   logic [15:0]        out_count_ff, out_count_in;
   logic               out_nul_ff, out_nul_in;

   logic               emit;
   logic               at_nul;
   logic               advance;
   logic [W-1:0]       signed_val;

   // walk the phases for one item, each phase may fall through to the next
   always_comb begin
      logic done;
      phase_in = phase_ff;
      neg_in   = neg_ff;
      base_in  = base_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      emit     = 1'b0;
      at_nul   = 1'b0;
      done     = 1'b0;
      if (entry.start) begin
         phase_in = tip_pkg::PH_SPACE;
         neg_in   = 1'b0;
         acc_in   = '0;
         cnt_in   = '0;
         base_in  = entry.base;
      end
      if (phase_in == tip_pkg::PH_SPACE) begin
         if (entry.is_space) begin
            cnt_in = tip_pkg::count_inc(cnt_in);
            done   = 1'b1;
         end else begin
            phase_in = tip_pkg::PH_SIGNED;
            if (entry.is_sign) begin
               neg_in = entry.is_minus;
               cnt_in = tip_pkg::count_inc(cnt_in);
               done   = 1'b1;
            end
         end
      end
      if (!done && phase_in == tip_pkg::PH_SIGNED) begin
         if ((base_in == tip_pkg::BASE_SIXTEEN || base_in == tip_pkg::BASE_AUTO)
             && entry.is_zero) begin
            cnt_in   = tip_pkg::count_inc(cnt_in);
            phase_in = tip_pkg::PH_ZERO;
            done     = 1'b1;
         end else begin
            if (base_in == tip_pkg::BASE_AUTO) begin
               base_in = tip_pkg::BASE_TEN;
            end
            phase_in = tip_pkg::PH_DIGITS;
         end
      end
      if (!done && phase_in == tip_pkg::PH_ZERO) begin
         if (entry.is_x) begin
            cnt_in   = tip_pkg::count_inc(cnt_in);
            base_in  = tip_pkg::BASE_SIXTEEN;
            phase_in = tip_pkg::PH_DIGITS;
            done     = 1'b1;
         end else begin
            if (base_in == tip_pkg::BASE_AUTO) begin
               base_in = tip_pkg::BASE_EIGHT;
            end
            phase_in = tip_pkg::PH_DIGITS;
         end
      end
      if (!done && phase_in == tip_pkg::PH_DIGITS) begin
         if (entry.is_nul) begin
            emit     = 1'b1;
            at_nul   = 1'b1;
            phase_in = tip_pkg::PH_IDLE;
         end else if (entry.digit >= base_in) begin
            emit     = 1'b1;
            phase_in = tip_pkg::PH_IDLE;
         end else begin
            acc_in = acc_in * W'(base_in) + W'(entry.digit);
            cnt_in = tip_pkg::count_inc(cnt_in);
         end
      end
   end

   // an item that finishes needs room in the result register
   assign advance   = !entry_empty && (!emit || !out_valid_ff || rsp_pop);
   assign entry_pop = advance;

   assign signed_val = neg_in ? (W'(0) - acc_in) : acc_in;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      out_count_in = out_count_ff;
      out_nul_in   = out_nul_ff;
      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (advance && emit) begin
         out_valid_in = 1'b1;
         out_value_in = 64'($signed(signed_val));
         out_count_in = cnt_in;
         out_nul_in   = at_nul;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= tip_pkg::PH_IDLE;
         neg_ff       <= 1'b0;
         base_ff      <= tip_pkg::BASE_TEN;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            base_ff  <= base_in;
            acc_ff   <= acc_in;
            cnt_ff   <= cnt_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
      out_count_ff <= out_count_in;
      out_nul_ff   <= out_nul_in;
   end

   assign rsp_empty                 = !out_valid_ff;
   assign rsp_parsed_value          = out_value_ff;
   assign rsp_consumed_count        = out_count_ff;
   assign rsp_stopped_at_terminator = out_nul_ff;

endmodule

[design/text_to_integer_parser.sv]
// top level of the streaming text to integer parser
// Takes one text byte per cycle while req_full is low and no finishing byte meets
// an unpopped result: each byte is classified on entry, waits in a four-item
// queue and passes the back unit, whose single multiply-add by the base sets the
// rate. A stop byte is written into the queue, then by the back unit into the
// rsp_ result register. While a result waits to be popped, bytes that do not
// end a conversion keep flowing; a second finishing byte waits in the queue,
// and req_full rises once four items are held. The base register takes a write
// in any cycle (csr_ready is always high) and is used from the next start byte.
module text_to_integer_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [5:0]         csr_requested_base,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_character,
   input  logic               req_start_of_text,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [63:0] rsp_parsed_value,
   output logic [15:0]        rsp_consumed_count,
   output logic               rsp_stopped_at_terminator
);

   tip_pkg::entry_type front_entry;
   tip_pkg::entry_type head_entry;
   logic               queue_empty;
   logic               queue_pop;

   tip_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_requested_base (csr_requested_base),
      .req_character      (req_character),
      .req_start_of_text  (req_start_of_text),
      .entry              (front_entry)
   );

   tip_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .push_entry (front_entry),
      .pop        (queue_pop),
      .empty      (queue_empty),
      .head_entry (head_entry)
   );

   tip_back u_back (
      .clock                     (clock),
      .reset                     (reset),
      .entry_empty               (queue_empty),
      .entry                     (head_entry),
      .entry_pop                 (queue_pop),
      .rsp_empty                 (rsp_empty),
      .rsp_pop                   (rsp_pop),
      .rsp_parsed_value          (rsp_parsed_value),
      .rsp_consumed_count        (rsp_consumed_count),
      .rsp_stopped_at_terminator (rsp_stopped_at_terminator)
   );

endmodule

[design/tip_checker.sv]
// port level checks of the text to integer parser and their bind
module tip_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_push,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic signed [63:0] rsp_parsed_value,
   input logic [15:0]        rsp_consumed_count
);

   // the result side comes out of reset empty and the input queue not full
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // a waiting result stays until popped
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_parsed_value)
                                 && $stable(rsp_consumed_count))
      else $error("result changed or vanished while stalled");

   // a nonzero value needs a nonzero consumed count
   a_value_has_count: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_parsed_value != 64'sd0 |-> rsp_consumed_count != 16'd0)
      else $error("nonzero value with zero count");

   // the input queue only fills through a push
   a_full_after_push: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push))
      else $error("full rose without a push");

endmodule

bind text_to_integer_parser tip_checker u_tip_checker (
   .clock              (clock),
   .reset              (reset),
   .req_push           (req_push),
   .req_full           (req_full),
   .rsp_empty          (rsp_empty),
   .rsp_pop            (rsp_pop),
   .rsp_parsed_value   (rsp_parsed_value),
   .rsp_consumed_count (rsp_consumed_count)
);

[sim/tb_text_to_integer_parser.sv]
// self-checking testbench of the streaming text to integer parser
module tb_text_to_integer_parser;

   localparam int ITEMS_PER_PHASE = 70;
   localparam int SETTLE_CYCLES   = 10;

   typedef struct {
      logic signed [63:0] value;
      logic [15:0]        count;
      logic               at_nul;
   } conversion_result_type;

   class conversion_scoreboard_type;
      logic [5:0]            base_register;
      tip_pkg::phase_type    phase;
      logic                  negative;
      logic [5:0]            base;
      logic [63:0]           acc;
      logic [15:0]           consumed;
      conversion_result_type expected_conversions[$];
      int                    failures;
      int                    accepted;
      int                    checked;

      function new();
         base_register = tip_pkg::BASE_AUTO;
         phase = tip_pkg::PH_IDLE;
         negative = 1'b0;
         base = tip_pkg::BASE_TEN;
         acc = '0;
         consumed = '0;
      endfunction

      function void set_base(input logic [5:0] value);
         base_register = value;
      endfunction

      function int pending();
         return expected_conversions.size();
      endfunction

      function void bump();
         if (consumed < 16'(tip_pkg::MAX_CONSUMED)) begin
            consumed++;
         end
      endfunction

      function logic [5:0] digit_value(input logic [7:0] c);
         logic [7:0] u;
         u = (c >= tip_pkg::CHAR_LOWER_A && c <= tip_pkg::CHAR_LOWER_Z) ? c - 8'd32 : c;
         if (u >= tip_pkg::CHAR_ZERO && u <= tip_pkg::CHAR_NINE) begin
            return 6'(u - tip_pkg::CHAR_ZERO);
         end
         if (u >= tip_pkg::CHAR_UPPER_A && u <= tip_pkg::CHAR_UPPER_Z) begin
            return 6'(u - tip_pkg::CHAR_UPPER_A + 8'd10);
         end
         return tip_pkg::NO_DIGIT;
      endfunction

      function void finish_conversion(input logic at_nul);
         conversion_result_type r;
         r.value = negative ? -acc : acc;
         r.count = consumed;
         r.at_nul = at_nul;
         expected_conversions.push_back(r);
         phase = tip_pkg::PH_IDLE;
      endfunction

      // advance the parse by one accepted byte
      function void note_byte(input logic [7:0] c, input logic start);
         logic [5:0] d;
         accepted++;
         if (start) begin
            phase = tip_pkg::PH_SPACE;
            negative = 1'b0;
            acc = '0;
            consumed = '0;
            base = base_register;
            if (base == tip_pkg::BASE_ONE || base > tip_pkg::BASE_MAX) begin
               base = tip_pkg::BASE_TEN;
            end
         end
         if (phase == tip_pkg::PH_SPACE) begin
            if (c == tip_pkg::CHAR_SPACE || c == tip_pkg::CHAR_TAB) begin
               bump();
               return;
            end
            phase = tip_pkg::PH_SIGNED;
            if (c == tip_pkg::CHAR_MINUS || c == tip_pkg::CHAR_PLUS) begin
               negative = (c == tip_pkg::CHAR_MINUS);
               bump();
               return;
            end
         end
         if (phase == tip_pkg::PH_SIGNED) begin
            if ((base == tip_pkg::BASE_SIXTEEN || base == tip_pkg::BASE_AUTO)
                && c == tip_pkg::CHAR_ZERO) begin
               bump();
               phase = tip_pkg::PH_ZERO;
               return;
            end
            if (base == tip_pkg::BASE_AUTO) begin
               base = tip_pkg::BASE_TEN;
            end
            phase = tip_pkg::PH_DIGITS;
         end
         if (phase == tip_pkg::PH_ZERO) begin
            if (c == tip_pkg::CHAR_UPPER_X || c == tip_pkg::CHAR_LOWER_X) begin
               bump();
               base = tip_pkg::BASE_SIXTEEN;
               phase = tip_pkg::PH_DIGITS;
               return;
            end
            // a lone zero in auto base means octal
            if (base == tip_pkg::BASE_AUTO) begin
               base = tip_pkg::BASE_EIGHT;
            end
            phase = tip_pkg::PH_DIGITS;
         end
         if (phase == tip_pkg::PH_DIGITS) begin
            if (c == tip_pkg::CHAR_NUL) begin
               finish_conversion(1'b1);
               return;
            end
            d = digit_value(c);
            if (d >= base) begin
               finish_conversion(1'b0);
               return;
            end
            acc = acc * 64'(base) + 64'(d);
            bump();
         end
      endfunction

      function void check_result(input logic signed [63:0] value, input logic [15:0] count,
                                 input logic at_nul);
         conversion_result_type e;
         if (expected_conversions.size() == 0) begin
            $error("result with none expected: value %0d count %0d", value, count);
            failures++;
            return;
         end
         e = expected_conversions.pop_front();
         checked++;
         if (value !== e.value) begin
            $error("parsed_value: expected %0d, got %0d", e.value, value);
            failures++;
         end
         if (count !== e.count) begin
            $error("consumed_count: expected %0d, got %0d", e.count, count);
            failures++;
         end
         if (at_nul !== e.at_nul) begin
            $error("stopped_at_terminator: expected %0b, got %0b", e.at_nul, at_nul);
            failures++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               csr_valid;
   logic               csr_ready;
   logic [5:0]         csr_requested_base;
   logic               req_push;
   logic               req_full;
   logic [7:0]         req_character;
   logic               req_start_of_text;
   logic               rsp_empty;
   logic               rsp_pop;
   logic signed [63:0] rsp_parsed_value;
   logic [15:0]        rsp_consumed_count;
   logic               rsp_stopped_at_terminator;

   conversion_scoreboard_type board = new();
   int send_mode = 1;
   int cur_base = tip_pkg::BASE_AUTO;
   int phase_items;
   int base_writes;

   text_to_integer_parser DUT (
      .clock                     (clock),
      .reset                     (reset),
      .csr_valid                 (csr_valid),
      .csr_ready                 (csr_ready),
      .csr_requested_base        (csr_requested_base),
      .req_push                  (req_push),
      .req_full                  (req_full),
      .req_character             (req_character),
      .req_start_of_text         (req_start_of_text),
      .rsp_empty                 (rsp_empty),
      .rsp_pop                   (rsp_pop),
      .rsp_parsed_value          (rsp_parsed_value),
      .rsp_consumed_count        (rsp_consumed_count),
      .rsp_stopped_at_terminator (rsp_stopped_at_terminator)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // mode 0 never idles, mode 1 idles uniformly, mode 2 idles now and then
   function automatic int idle_gap(input int mode);
      case (mode)
         0: return 0;
         1: return $urandom_range(0, 18);
         default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
      endcase
   endfunction

   task automatic send_char(input logic [7:0] c, input logic start);
      int gap;
      gap = idle_gap(send_mode);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_character <= c;
      req_start_of_text <= start;
      do @(posedge clock); while (req_full);
      board.note_byte(c, start);
   endtask

   task automatic send_text(input string s, input logic with_start);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], with_start && i == 0);
      end
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one well-formed conversion with random content, or a burst of noise
   task automatic send_conversion();
      logic [7:0] text[$];
      logic [7:0] c;
      string      extreme;
      int         eff;
      int         radix;
      int         ndig;
      int         kind;
      int         d;
      if ($urandom_range(0, 9) == 0) send_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 59) == 0) wait_drained();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 1));
            phase_items++;
         end
         return;
      end
      eff = cur_base;
      if (eff == tip_pkg::BASE_ONE || eff > tip_pkg::BASE_MAX) eff = tip_pkg::BASE_TEN;
      radix = eff;
      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(1, 3))
            text.push_back($urandom_range(0, 1) ? tip_pkg::CHAR_SPACE : tip_pkg::CHAR_TAB);
      end
      kind = $urandom_range(0, 3);
      if (kind == 0) text.push_back(tip_pkg::CHAR_PLUS);
      else if (kind == 1) text.push_back(tip_pkg::CHAR_MINUS);
      kind = $urandom_range(0, 2);
      if ((eff == tip_pkg::BASE_SIXTEEN || eff == tip_pkg::BASE_AUTO) && kind == 0) begin
         text.push_back(tip_pkg::CHAR_ZERO);
         text.push_back($urandom_range(0, 1) ? tip_pkg::CHAR_UPPER_X : tip_pkg::CHAR_LOWER_X);
         radix = tip_pkg::BASE_SIXTEEN;
      end else if (eff == tip_pkg::BASE_AUTO && kind == 1) begin
         text.push_back(tip_pkg::CHAR_ZERO);
         radix = tip_pkg::BASE_EIGHT;
      end else if (eff == tip_pkg::BASE_AUTO) begin
         radix = tip_pkg::BASE_TEN;
      end
      kind = $urandom_range(0, 19);
      if (radix == tip_pkg::BASE_TEN && kind == 0) begin
         // largest magnitudes of a signed 64 bit value
         extreme = $urandom_range(0, 1) ? "9223372036854775807" : "9223372036854775808";
         for (int i = 0; i < extreme.len(); i++) text.push_back(extreme[i]);
      end else begin
         ndig = (kind == 1) ? 0 : (kind < 16) ? $urandom_range(1, 8) : $urandom_range(10, 30);
         for (int i = 0; i < ndig; i++) begin
            d = $urandom_range(0, radix - 1);
            // a leading zero would switch auto base to octal
            if (i == 0 && eff == tip_pkg::BASE_AUTO && radix == tip_pkg::BASE_TEN && d == 0)
               d = 1;
            if (d < 10) c = tip_pkg::CHAR_ZERO + 8'(d);
            else c = ($urandom_range(0, 1) ? tip_pkg::CHAR_UPPER_A : tip_pkg::CHAR_LOWER_A)
                     + 8'(d - 10);
            text.push_back(c);
         end
      end
      kind = $urandom_range(0, 19);
      if (kind < 10) text.push_back(tip_pkg::CHAR_NUL);
      else if (kind < 13) text.push_back(8'($urandom_range(128, 255)));
      else if (kind < 18) text.push_back(8'($urandom_range(1, 127)));
      // otherwise left open, the next start drops it
      if (text.size() == 0) text.push_back(tip_pkg::CHAR_NUL);
      foreach (text[i]) send_char(text[i], i == 0);
      phase_items += text.size();
      repeat ($urandom_range(0, 2)) begin
         send_char(8'($urandom_range(0, 255)), 1'b0);
         phase_items++;
      end
   endtask

   // result side: random pop stalls, in stretches of one mode
   initial begin
      int gap;
      int mode;
      int left;
      rsp_pop <= 1'b0;
      left = 0;
      mode = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (left == 0) begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(10, 60);
         end
         left--;
         gap = idle_gap(mode);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         board.check_result(rsp_parsed_value, rsp_consumed_count, rsp_stopped_at_terminator);
      end
   end

   initial begin
      logic [5:0] base_plan[$];
      reset <= 1'b1;
      req_push <= 1'b0;
      req_character <= '0;
      req_start_of_text <= 1'b0;
      csr_valid <= 1'b0;
      csr_requested_base <= '0;
      base_plan = '{6'd16, 6'd10, 6'd0, 6'd2, 6'd36, 6'd37, 6'd63, 6'd1, 6'd8, 6'd7,
                    6'd20, 6'd35};
      base_plan.push_back(6'($urandom_range(0, 63)));
      base_plan.push_back(6'($urandom_range(2, 36)));
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part, auto base from reset
      send_char(tip_pkg::CHAR_UPPER_A, 1'b0);
      send_text(" \t-0xg", 1'b1);
      send_text("078", 1'b1);
      send_char(tip_pkg::CHAR_PLUS, 1'b1);
      send_char(tip_pkg::CHAR_NUL, 1'b0);
      send_text("12", 1'b1);
      send_text("42", 1'b1);
      send_char(8'hFF, 1'b0);
      send_text("9", 1'b1);
      send_char(tip_pkg::CHAR_NUL, 1'b0);
      send_char(tip_pkg::CHAR_NUL, 1'b0);

      for (int p = 0; p < base_plan.size(); p++) begin
         wait_drained();
         csr_valid <= 1'b1;
         csr_requested_base <= base_plan[p];
         do @(posedge clock); while (!csr_ready);
         csr_valid <= 1'b0;
         board.set_base(base_plan[p]);
         cur_base = base_plan[p];
         base_writes++;
         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) send_conversion();
      end
      wait_drained();

      $display("accepted %0d text bytes, checked %0d conversions", board.accepted,
               board.checked);
      $display("base register written %0d times, auto base through 63 included", base_writes);
      if (board.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
